/* hw/rtl/adsr_pkg.sv */
// Shared types, constants and Q1.15 helpers for the ADSR envelope generator.
// No dependencies; used by adsr_datapath and adsr_envelope_generator.
package adsr_pkg;

	// Q1.15 fixed point: 32768 is 1.0
	localparam logic [15:0] ONE_Q15        = 16'd32768;
	localparam logic [15:0] OVERSHOOT_Q15  = 16'd33423;
	localparam logic [15:0] SNAP_EPS       = 16'd3;
	localparam logic [15:0] VEL_MIN_AMOUNT = 16'd33;

	// floor(x / 1000) for x <= 32768 as (x * RECIP_1000) >> RECIP_SHIFT
	localparam logic [16:0] RECIP_1000  = 17'd67109;
	localparam int          RECIP_SHIFT = 26;

	// register reset values
	localparam logic [15:0] RST_ATTACK_COEFF  = 16'd328;
	localparam logic [15:0] RST_DECAY_COEFF   = 16'd66;
	localparam logic [15:0] RST_RELEASE_COEFF = 16'd66;
	localparam logic [15:0] RST_SUSTAIN_LEVEL = 16'd22938;
	localparam logic [15:0] RST_VEL_AMOUNT    = 16'd0;
	localparam logic        RST_ATTACK_MODE   = 1'b0;

	// register indexes on the configuration port
	localparam logic [2:0] REG_ATTACK_COEFF  = 3'd0;
	localparam logic [2:0] REG_DECAY_COEFF   = 3'd1;
	localparam logic [2:0] REG_RELEASE_COEFF = 3'd2;
	localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd3;
	localparam logic [2:0] REG_VEL_AMOUNT    = 3'd4;
	localparam logic [2:0] REG_ATTACK_MODE   = 3'd5;

	// commands
	localparam logic [1:0] CMD_TICK     = 2'd0;
	localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
	localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	typedef struct packed {
		logic [15:0] attack_coeff;
		logic [15:0] decay_coeff;
		logic [15:0] release_coeff;
		logic [15:0] sustain_level;
		logic [15:0] velocity_amount;
		logic        attack_mode;
	} cfg_t;

	typedef struct packed {
		stage_t      stage;
		logic [15:0] level;
		logic [15:0] target;
		logic [15:0] peak;
		logic [15:0] coeff;
	} env_state_t;

	// clamp a Q1.15 value to 1.0
	function automatic logic [15:0] sat_q15(input logic [15:0] v);
		return (v > ONE_Q15) ? ONE_Q15 : v;
	endfunction

	// (a * b) / 32768, rounding half up; both operands at most 1.0
	function automatic logic [15:0] mul_round(input logic [15:0] a, input logic [15:0] b);
		logic [32:0] prod;
		prod = 33'(a) * 33'(b) + 33'd16384;
		return prod[30:15];
	endfunction

endpackage

/* hw/rtl/adsr_datapath.sv */
// Next-state logic of the envelope: peak, one-pole step, snaps and stage moves.
// Purely combinational; depends on adsr_pkg.
module adsr_datapath (
	input  logic [1:0]              cmd,
	input  logic [15:0]             note_velocity,
	input  adsr_pkg::cfg_t          cfg,
	input  adsr_pkg::env_state_t    cur,
	output adsr_pkg::env_state_t    nxt
);

	logic [15:0] vel_sat;
	logic [15:0] amt_sat;
	logic [15:0] vel_term;
	logic [15:0] peak_new;
	logic [15:0] sus_target;
	logic [15:0] step_tgt;
	logic [15:0] step_coeff;
	logic        step_up;
	logic [15:0] step_diff;
	logic [32:0] step_prod;
	logic [15:0] step_mag;
	logic [15:0] step_level;
	logic [32:0] thr_prod;
	logic [15:0] atk_thr;
	logic [16:0] dec_limit;

	// peak for a note-on, scaled by velocity
	assign vel_sat  = adsr_pkg::sat_q15(note_velocity);
	assign amt_sat  = adsr_pkg::sat_q15(cfg.velocity_amount);
	assign vel_term = adsr_pkg::mul_round(amt_sat, vel_sat);
	assign peak_new = (amt_sat >= adsr_pkg::VEL_MIN_AMOUNT) ?
		(adsr_pkg::ONE_Q15 - amt_sat + vel_term) : adsr_pkg::ONE_Q15;

	// sustain level relative to the peak: decay target and held sustain value
	assign sus_target = adsr_pkg::mul_round(adsr_pkg::sat_q15(cfg.sustain_level), cur.peak);

	// one-pole target and coefficient by stage
	always_comb begin
		step_tgt   = cur.target;
		step_coeff = cur.coeff;
		case (cur.stage)
			adsr_pkg::ST_ATTACK: begin
				if (cfg.attack_mode) begin
					step_tgt = adsr_pkg::OVERSHOOT_Q15;
				end else begin
					step_tgt   = cur.peak;
					step_coeff = adsr_pkg::sat_q15(cfg.attack_coeff);
				end
			end
			adsr_pkg::ST_RELEASE: step_tgt = '0;
			default: step_tgt = cur.target;
		endcase
	end

	// step of ceil(coeff * |target - level| / 32768) toward the target
	assign step_up    = (step_tgt >= cur.level);
	assign step_diff  = step_up ? (step_tgt - cur.level) : (cur.level - step_tgt);
	assign step_prod  = 33'(step_coeff) * 33'(step_diff) + 33'd32767;
	assign step_mag   = step_prod[30:15];
	assign step_level = step_up ? (cur.level + step_mag) : (cur.level - step_mag);

	// attack ends at level >= target - floor(target / 1000), i.e. level * 1000 >= target * 999
	assign thr_prod  = {16'd0, cur.target} * {16'd0, adsr_pkg::RECIP_1000};
	assign atk_thr   = cur.target - {9'd0, thr_prod[adsr_pkg::RECIP_SHIFT +: 7]};
	assign dec_limit = {1'b0, cur.target} + {1'b0, adsr_pkg::SNAP_EPS};

	always_comb begin
		nxt = cur;
		case (cmd)
			adsr_pkg::CMD_TICK: begin
				unique case (cur.stage)
					adsr_pkg::ST_ATTACK: begin
						nxt.level = step_level;
						if (step_level >= atk_thr) begin
							nxt.level  = cur.target;
							nxt.stage  = adsr_pkg::ST_DECAY;
							nxt.target = sus_target;
							nxt.coeff  = adsr_pkg::sat_q15(cfg.decay_coeff);
						end
					end
					adsr_pkg::ST_DECAY: begin
						nxt.level = step_level;
						if ({1'b0, step_level} <= dec_limit) begin
							nxt.level = cur.target;
							nxt.stage = adsr_pkg::ST_SUSTAIN;
						end
					end
					adsr_pkg::ST_SUSTAIN: nxt.level = sus_target;
					adsr_pkg::ST_RELEASE: begin
						nxt.level = step_level;
						if (step_level <= adsr_pkg::SNAP_EPS) begin
							nxt.level = '0;
							nxt.stage = adsr_pkg::ST_IDLE;
						end
					end
					default: begin
						nxt.level = '0;
						nxt.stage = adsr_pkg::ST_IDLE;
					end
				endcase
			end
			adsr_pkg::CMD_NOTE_ON: begin
				nxt.peak   = peak_new;
				nxt.target = peak_new;
				nxt.stage  = adsr_pkg::ST_ATTACK;
				nxt.coeff  = adsr_pkg::sat_q15(cfg.attack_coeff);
			end
			adsr_pkg::CMD_NOTE_OFF: begin
				if (cur.stage != adsr_pkg::ST_IDLE) begin
					nxt.stage  = adsr_pkg::ST_RELEASE;
					nxt.target = '0;
					nxt.coeff  = adsr_pkg::sat_q15(cfg.release_coeff);
				end
			end
			default: nxt = cur;
		endcase
	end

endmodule

/* hw/rtl/adsr_envelope_generator.sv */
// Top level of the ADSR envelope generator: stream ports, input and output
// registers, envelope state and configuration. Depends on adsr_pkg, adsr_datapath.
//
// Channel  Dir  Handshake                Payload
// s_axis   in   s_axis_tvalid/tready     tdata: note_velocity; tuser: cmd
// m_axis   out  m_axis_tvalid/tready     tdata: level; tuser: phase
// cfg      in   cfg_valid/cfg_ready      cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled.
// The envelope update is one pass through adsr_datapath between the input
// register and the output register, with the state written in that cycle.
// Reset restores the register defaults and an idle envelope at level zero.
// A stalled output holds its word; the input register keeps taking words
// as long as the output register is empty or being drained.
module adsr_envelope_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] note_velocity
	input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] level
	output logic [2:0]  m_axis_tuser,   // [2:0] phase
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	adsr_pkg::cfg_t       cfg_q;
	adsr_pkg::env_state_t env_q;
	adsr_pkg::env_state_t env_nxt;

	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [15:0] vel_s1;
	logic        advance;

	logic        out_valid_q;
	logic [15:0] out_level_q;
	adsr_pkg::stage_t out_phase_q;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_coeff    <= adsr_pkg::RST_ATTACK_COEFF;
			cfg_q.decay_coeff     <= adsr_pkg::RST_DECAY_COEFF;
			cfg_q.release_coeff   <= adsr_pkg::RST_RELEASE_COEFF;
			cfg_q.sustain_level   <= adsr_pkg::RST_SUSTAIN_LEVEL;
			cfg_q.velocity_amount <= adsr_pkg::RST_VEL_AMOUNT;
			cfg_q.attack_mode     <= adsr_pkg::RST_ATTACK_MODE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				adsr_pkg::REG_ATTACK_COEFF:  cfg_q.attack_coeff    <= cfg_data;
				adsr_pkg::REG_DECAY_COEFF:   cfg_q.decay_coeff     <= cfg_data;
				adsr_pkg::REG_RELEASE_COEFF: cfg_q.release_coeff   <= cfg_data;
				adsr_pkg::REG_SUSTAIN_LEVEL: cfg_q.sustain_level   <= cfg_data;
				adsr_pkg::REG_VEL_AMOUNT:    cfg_q.velocity_amount <= cfg_data;
				adsr_pkg::REG_ATTACK_MODE:   cfg_q.attack_mode     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register advances into the output register when that has room
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1 <= s_axis_tuser;
			vel_s1 <= s_axis_tdata;
		end
	end

	adsr_datapath u_datapath (
		.cmd           (cmd_s1),
		.note_velocity (vel_s1),
		.cfg           (cfg_q),
		.cur           (env_q),
		.nxt           (env_nxt)
	);

	// envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q.stage  <= adsr_pkg::ST_IDLE;
			env_q.level  <= '0;
			env_q.target <= '0;
			env_q.peak   <= '0;
			env_q.coeff  <= '0;
		end else if (advance) begin
			env_q <= env_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_level_q <= env_nxt.level;
			out_phase_q <= env_nxt.stage;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_level_q;
	assign m_axis_tuser  = out_phase_q;

	// level never exceeds 1.0
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q.level <= adsr_pkg::ONE_Q15)
		else $error("envelope level above 1.0");

	// idle envelope sits at zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(env_q.stage == adsr_pkg::ST_IDLE) |-> (env_q.level == '0))
		else $error("idle envelope with non-zero level");

	// during attack the target is the peak
	a_attack_target: assert property (@(posedge clk) disable iff (!arst_n)
		(env_q.stage == adsr_pkg::ST_ATTACK) |-> (env_q.target == env_q.peak))
		else $error("attack target differs from peak");

	// release always heads for zero
	a_release_target: assert property (@(posedge clk) disable iff (!arst_n)
		(env_q.stage == adsr_pkg::ST_RELEASE) |-> (env_q.target == '0))
		else $error("release target not zero");

	// a word leaving the input register shows up as a result
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_valid_q && out_level_q == $past(env_nxt.level)))
		else $error("result word lost");

endmodule
